// ----- sv/lpg_pkg.sv -----
package lpg_pkg;

  // Fixed field widths of the line command and the point result
  localparam int COORD_W = 6;
  localparam int TAG_W   = 8;
  localparam int SUM_W   = COORD_W + 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new line command
    logic step;   // present the current point and advance
  } lpg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;   // current point is the final point of the line
  } lpg_status_t;

endpackage

// ----- sv/lpg_ctrl.sv -----
module lpg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  lpg_pkg::lpg_status_t status,
  output lpg_pkg::lpg_cmd_t    cmd,
  output logic                 busy,
  output logic                 out_valid
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == ST_RUN);
  assign out_valid = (state_r == ST_RUN);

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy)
    else $error("accepted command did not start a walk");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && status.last) |=> !busy)
    else $error("walk continued past the final point");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !status.last) |=> busy)
    else $error("walk ended before the final point");

endmodule

// ----- sv/lpg_dp.sv -----
module lpg_dp #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpg_pkg::lpg_cmd_t                   cmd,
  output lpg_pkg::lpg_status_t                status,
  input  logic [lpg_pkg::COORD_W-1:0]         x_start,
  input  logic [lpg_pkg::COORD_W-1:0]         y_start,
  input  logic [lpg_pkg::COORD_W-1:0]         x_end,
  input  logic [lpg_pkg::COORD_W-1:0]         y_end,
  input  logic [lpg_pkg::TAG_W-1:0]           tag,
  output logic [lpg_pkg::COORD_W-1:0]         point_x,
  output logic [lpg_pkg::COORD_W-1:0]         point_y,
  output logic [lpg_pkg::TAG_W-1:0]           point_tag,
  output logic                                last_point
);

  localparam logic [lpg_pkg::COORD_W-1:0] MaxCoord = lpg_pkg::COORD_W'(GRID_SIZE - 1);

  logic [lpg_pkg::COORD_W-1:0] x0c, y0c, x1c, y1c;
  logic [lpg_pkg::COORD_W-1:0] xa, ya, xb, yb;
  logic [lpg_pkg::COORD_W-1:0] dx, ady;
  logic                        swap, neg, steep;

  logic [lpg_pkg::COORD_W-1:0] x_r, y_r, acc_r, major_r, minor_r, cnt_r;
  logic [lpg_pkg::TAG_W-1:0]   tag_r;
  logic                        steep_r, neg_r;

  logic [lpg_pkg::SUM_W-1:0]   acc_sum;
  logic                        carry;

  // Saturate coordinates to the grid
  assign x0c = (x_start > MaxCoord) ? MaxCoord : x_start;
  assign y0c = (y_start > MaxCoord) ? MaxCoord : y_start;
  assign x1c = (x_end   > MaxCoord) ? MaxCoord : x_end;
  assign y1c = (y_end   > MaxCoord) ? MaxCoord : y_end;

  // Order endpoints so x ascends, then pick the major axis
  assign swap  = (x0c > x1c);
  assign xa    = swap ? x1c : x0c;
  assign ya    = swap ? y1c : y0c;
  assign xb    = swap ? x0c : x1c;
  assign yb    = swap ? y0c : y1c;
  assign dx    = xb - xa;
  assign neg   = (yb < ya);
  assign ady   = neg ? (ya - yb) : (yb - ya);
  assign steep = (ady >= dx);

  // Exact quotient tracking: remainder plus minor delta, at most one wrap per step
  assign acc_sum = {1'b0, acc_r} + {1'b0, minor_r};
  assign carry   = (acc_sum >= {1'b0, major_r});

  // Load a command, or advance one point along the line
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= xa;
      y_r     <= ya;
      acc_r   <= '0;
      major_r <= steep ? ady : dx;
      minor_r <= steep ? dx : ady;
      cnt_r   <= steep ? ady : dx;
      steep_r <= steep;
      neg_r   <= neg;
      tag_r   <= tag;
    end else if (cmd.step) begin
      acc_r <= carry ? lpg_pkg::COORD_W'(acc_sum - {1'b0, major_r})
                     : lpg_pkg::COORD_W'(acc_sum);
      if (!steep_r || carry) begin
        x_r <= x_r + 1'b1;
      end
      if (steep_r || carry) begin
        y_r <= neg_r ? (y_r - 1'b1) : (y_r + 1'b1);
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign status.last = (cnt_r == '0);
  assign point_x     = x_r;
  assign point_y     = y_r;
  assign point_tag   = tag_r;
  assign last_point  = status.last;

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !status.last) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("point count did not advance by one");

  a_rem_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !status.last) |-> (acc_r < major_r))
    else $error("slope remainder reached the major delta");

  a_x_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !status.last) |=>
      (x_r == $past(x_r) || x_r == $past(x_r) + 1'b1))
    else $error("x moved by more than one or backward");

endmodule

// ----- sv/line_point_generator.sv -----
// The first point appears in the cycle after the command transfer.
// A line of n major-axis steps emits n+1 points, one per cycle (1 to GRID_SIZE).
// A new command is taken only in idle, after the final point of the current line has been
// emitted; the controller does not accept a new command while a walk is running.
// Points are strobed by out_valid for one cycle each; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any walk.
module line_point_generator #(
  parameter int GRID_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lpg_pkg::COORD_W-1:0] in_x_start,
  input  logic [lpg_pkg::COORD_W-1:0] in_y_start,
  input  logic [lpg_pkg::COORD_W-1:0] in_x_end,
  input  logic [lpg_pkg::COORD_W-1:0] in_y_end,
  input  logic [lpg_pkg::TAG_W-1:0]   in_tag,
  output logic                        out_valid,
  output logic [lpg_pkg::COORD_W-1:0] out_point_x,
  output logic [lpg_pkg::COORD_W-1:0] out_point_y,
  output logic [lpg_pkg::TAG_W-1:0]   out_point_tag,
  output logic                        out_last_point
);

  lpg_pkg::lpg_cmd_t    cmd;
  lpg_pkg::lpg_status_t status;

  // Sequence the walk
  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Compute the points
  lpg_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .tag        (in_tag),
    .point_x    (out_point_x),
    .point_y    (out_point_y),
    .point_tag  (out_point_tag),
    .last_point (out_last_point)
  );

endmodule
